@@ hdl/aunp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aunp_pkg
// Types and constants shared by the ascii unsigned number parser modules.
// ---------------------------------------------------------------------------
package aunp_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [5:0] LETTER_OFFSET = 6'd10;

    localparam logic [5:0]  BASE_RESET = 6'd10;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_OK       = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // one classified character: digit or terminator, with its worth
    typedef struct packed {
        logic       is_digit;
        logic [5:0] worth;
    } t_item;

endpackage
`default_nettype wire

@@ hdl/aunp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aunp_front
// Accepts characters and classifies each as a digit of the current base
// or as the end of a number.
// ---------------------------------------------------------------------------
module aunp_front (
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_char,
    input  wire logic [5:0]        i_base,
    input  wire logic              i_room,
    output logic                   o_push,
    output aunp_pkg::t_item        o_item
);

    logic       w_known;
    logic [5:0] w_worth;
    logic [7:0] w_diff;

    always_comb begin
        w_known = 1'b1;
        w_diff  = 8'd0;
        w_worth = 6'd0;
        if (i_char >= aunp_pkg::CH_ZERO && i_char <= aunp_pkg::CH_NINE) begin
            w_diff  = i_char - aunp_pkg::CH_ZERO;
            w_worth = w_diff[5:0];
        end else if (i_char >= aunp_pkg::CH_UP_A && i_char <= aunp_pkg::CH_UP_Z) begin
            w_diff  = i_char - aunp_pkg::CH_UP_A;
            w_worth = w_diff[5:0] + aunp_pkg::LETTER_OFFSET;
        end else if (i_char >= aunp_pkg::CH_LO_A && i_char <= aunp_pkg::CH_LO_Z) begin
            w_diff  = i_char - aunp_pkg::CH_LO_A;
            w_worth = w_diff[5:0] + aunp_pkg::LETTER_OFFSET;
        end else begin
            w_known = 1'b0;
        end
    end

    assign o_item.is_digit = w_known && (w_worth < i_base);
    assign o_item.worth    = w_worth;
    assign o_push          = i_valid && i_room;
    assign o_ready         = i_room;

endmodule
`default_nettype wire

@@ hdl/aunp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aunp_queue
// Short queue of classified characters between front and back.
// ---------------------------------------------------------------------------
module aunp_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire aunp_pkg::t_item      i_item,
    output logic                      o_room,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output aunp_pkg::t_item           o_item
);

    localparam int CNT_W = aunp_pkg::Q_PTR_W + 1;

    aunp_pkg::t_item             r_mem [aunp_pkg::Q_DEPTH];
    logic [aunp_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [aunp_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]             r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr + (aunp_pkg::Q_PTR_W)'(i_push);
        n_rd_ptr = r_rd_ptr + (aunp_pkg::Q_PTR_W)'(i_pop);
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_room  = r_count < CNT_W'(aunp_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(aunp_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

@@ hdl/aunp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aunp_back
// Accumulates digits with overflow detection and registers one result
// per terminating character.
// ---------------------------------------------------------------------------
module aunp_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [5:0]        i_base,
    input  wire logic              i_valid,
    input  wire aunp_pkg::t_item   i_item,
    output logic                   o_pop,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic [1:0]             o_status,
    output logic [31:0]            o_value,
    output logic [15:0]            o_digits
);

    localparam int SUM_W = VALUE_BITS + 7;

    logic [VALUE_BITS-1:0] r_acc, n_acc;
    aunp_pkg::t_status     r_status, n_status;
    logic [15:0]           r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    aunp_pkg::t_status     r_out_status;
    logic [31:0]           r_out_value;
    logic [15:0]           r_out_digits;

    logic [SUM_W-1:0]      w_sum;
    logic                  w_ovf;
    logic                  w_digit;
    logic                  w_end;

    assign w_sum = SUM_W'(r_acc) * SUM_W'(i_base) + SUM_W'(i_item.worth);
    // any bit above the value width means the exact result did not fit
    assign w_ovf = |w_sum[SUM_W-1:VALUE_BITS];

    assign o_pop   = i_valid && (i_item.is_digit || !r_out_valid || i_res_ready);
    assign w_digit = o_pop && i_item.is_digit;
    assign w_end   = o_pop && !i_item.is_digit;

    always_comb begin
        n_acc       = r_acc;
        n_status    = r_status;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_digit) begin
            n_acc = w_sum[VALUE_BITS-1:0];
            if (w_ovf) begin
                n_status = aunp_pkg::ST_OVERFLOW;
            end else if (r_status == aunp_pkg::ST_NONE) begin
                n_status = aunp_pkg::ST_OK;
            end
            if (r_count != aunp_pkg::COUNT_MAX) begin
                n_count = r_count + 16'd1;
            end
        end else if (w_end) begin
            n_acc       = '0;
            n_status    = aunp_pkg::ST_NONE;
            n_count     = '0;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_status    <= aunp_pkg::ST_NONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_status    <= n_status;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_out_status <= r_status;
            r_out_value  <= 32'(r_acc);
            r_out_digits <= r_count;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = r_out_value;
    assign o_digits    = r_out_digits;

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> (r_acc == '0) && (r_count == '0) && (r_status == aunp_pkg::ST_NONE))
        else $error("number state not cleared after terminator");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_digit && r_status == aunp_pkg::ST_OVERFLOW) |=> r_status == aunp_pkg::ST_OVERFLOW)
        else $error("overflow status dropped before result");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |-> (!r_out_valid || i_res_ready))
        else $error("result register overwritten while held");

endmodule
`default_nettype wire

@@ hdl/ascii_unsigned_number_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ascii_unsigned_number_parser
// Converts a stream of ascii characters into unsigned numbers of a set base.
// ---------------------------------------------------------------------------
// usage:
//   s channel carries one character per transfer. digits 0-9 and letters
//   (either case, worth 10-35) below the base are accumulated; any other
//   character ends the number and produces one result on the m channel.
//   m_tuser holds the status (0 none, 1 ok, 2 overflow), m_tdata holds the
//   value (modulo 2^VALUE_BITS, shown in 32 bits) and the digit count.
//   the cfg channel sets the base; write it only while the block is idle.
// throughput: one character per cycle while s_tready is high, set by the
//   single multiply-add of the accumulator stage.
// result path: a terminating character passes through the classify queue
//   and the accumulator stage into the output register, where it waits
//   for m_tready.
// reset: base returns to 10, queue empties, number state clears.
// stall: a held result blocks only terminators; digits keep flowing until
//   the four-entry queue fills, then s_tready drops.
// ---------------------------------------------------------------------------
module ascii_unsigned_number_parser #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [5:0]  i_cfg_data,     // number_base
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,        // [7:0] char_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,        // [31:0] value, [47:32] digits_used
    output logic [1:0]       m_tuser         // [1:0] status
);

    logic [5:0]      r_base;
    logic            w_room;
    logic            w_push;
    aunp_pkg::t_item w_front_item;
    logic            w_q_valid;
    aunp_pkg::t_item w_q_item;
    logic            w_pop;
    logic [31:0]     w_value;
    logic [15:0]     w_digits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= aunp_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    aunp_front u_front (
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_char  (s_tdata),
        .i_base  (r_base),
        .i_room  (w_room),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    aunp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_room  (w_room),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    aunp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (r_base),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_res_valid (m_tvalid),
        .i_res_ready (m_tready),
        .o_status    (m_tuser),
        .o_value     (w_value),
        .o_digits    (w_digits)
    );

    assign m_tdata = {w_digits, w_value};

endmodule
`default_nettype wire
